@@ sv/bfil_pkg.sv @@
// ----------------------------------------------------------------------------
// bfil_pkg
// shared types, register indexes and constants of the bloom filter block
// ----------------------------------------------------------------------------
`default_nettype none
package bfil_pkg;

    localparam int MAX_HASHES   = 5;
    localparam int FILTER_DEPTH = 65536;
    localparam int IDX_W        = $clog2(FILTER_DEPTH);
    localparam int SIZE_W       = 17;
    localparam int HSEL_W       = $clog2(MAX_HASHES);
    localparam int WORD_W       = 32;
    localparam int WORDS        = FILTER_DEPTH / WORD_W;
    localparam int WADDR_W      = $clog2(WORDS);
    localparam int BIT_W        = $clog2(WORD_W);
    localparam int DIV_CNT_W    = 7;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic [3:0] REG_HASH_COUNT  = 4'd0;
    localparam logic [3:0] REG_FILTER_BITS = 4'd1;
    localparam logic [3:0] REG_CHUNK_BYTES = 4'd2;
    localparam logic [3:0] REG_COEF_0      = 4'd3;
    localparam logic [3:0] REG_COEF_LAST   = 4'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC,
        ST_NEXT,
        ST_DIV,
        ST_READ,
        ST_PROBE,
        ST_CLEAR,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic             acc_load;
        logic             acc_zero;
        logic             div_start;
        logic             mem_read;
        logic             mem_write;
        logic             clr_write;
        logic [HSEL_W-1:0] hsel;
        logic [WADDR_W-1:0] clr_addr;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic bit_set;
    } stat_t;

endpackage
`default_nettype wire

@@ sv/bfil_ctrl.sv @@
// ----------------------------------------------------------------------------
// bfil_ctrl
// sequencer: accumulate, reduce each hash, probe or set bits, clear sweep
// ----------------------------------------------------------------------------
`default_nettype none
module bfil_ctrl import bfil_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_fire,
    input  wire logic [1:0]  in_mode,
    input  wire logic        in_last,
    input  wire logic [2:0]  hash_count,
    input  wire logic        size_zero,
    input  wire logic        out_take,
    input  wire stat_t       stat,
    output cmd_t             cmd,
    output logic             in_ready,
    output logic             out_valid,
    output logic [1:0]       out_mode,
    output logic             out_hit,
    output logic             out_stored
);

    state_t              state_reg, state_next;
    logic [1:0]          mode_reg, mode_next;
    logic [HSEL_W-1:0]   h_reg, h_next;
    logic [2:0]          cnt_reg, cnt_next;
    logic                hit_reg, hit_next;
    logic                st_reg, st_next;
    logic [WADDR_W-1:0]  clr_reg, clr_next;
    logic [2:0]          cnt_eff;

    assign cnt_eff = (hash_count > 3'(MAX_HASHES)) ? 3'(MAX_HASHES) : hash_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            mode_reg  <= MODE_CLEAR;
            h_reg     <= '0;
            cnt_reg   <= '0;
            hit_reg   <= 1'b0;
            st_reg    <= 1'b0;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            h_reg     <= h_next;
            cnt_reg   <= cnt_next;
            hit_reg   <= hit_next;
            st_reg    <= st_next;
            clr_reg   <= clr_next;
        end
    end

    // reset sweep leaves no result; a clear op does
    logic from_op_reg, from_op_next;
    always_ff @(posedge aclk) begin
        if (!aresetn) from_op_reg <= 1'b0;
        else          from_op_reg <= from_op_next;
    end

    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        h_next       = h_reg;
        cnt_next     = cnt_reg;
        hit_next     = hit_reg;
        st_next      = st_reg;
        clr_next     = clr_reg;
        from_op_next = from_op_reg;
        cmd          = '0;
        cmd.hsel     = h_reg;
        cmd.clr_addr = clr_reg;
        in_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_fire) begin
                    mode_next = in_mode;
                    if (in_mode == MODE_CLEAR) begin
                        cmd.acc_zero = 1'b1;
                        clr_next     = '0;
                        from_op_next = 1'b1;
                        state_next   = ST_CLEAR;
                    end else if (in_mode != 2'd3) begin
                        cmd.acc_load = 1'b1;
                        state_next   = in_last ? ST_ACC : ST_IDLE;
                    end
                end
            end
            ST_ACC: begin
                h_next   = '0;
                cnt_next = cnt_eff;
                hit_next = !size_zero && (mode_reg == MODE_LOOKUP);
                st_next  = !size_zero && (mode_reg == MODE_INSERT);
                if (size_zero || cnt_eff == 3'd0) begin
                    cmd.acc_zero = 1'b1;
                    state_next   = ST_OUT;
                end else begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                if (stat.div_done) begin
                    cmd.mem_read = 1'b1;
                    state_next   = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_PROBE;
            end
            ST_PROBE: begin
                if (mode_reg == MODE_INSERT) cmd.mem_write = 1'b1;
                else if (!stat.bit_set)      hit_next = 1'b0;
                if (32'(h_reg) + 1 >= 32'(cnt_reg)) begin
                    cmd.acc_zero = 1'b1;
                    state_next   = ST_OUT;
                end else begin
                    h_next     = h_reg + 1'b1;
                    state_next = ST_NEXT;
                end
            end
            ST_CLEAR: begin
                cmd.clr_write = 1'b1;
                clr_next      = clr_reg + 1'b1;
                if (&clr_reg) begin
                    hit_next   = 1'b0;
                    st_next    = 1'b1;
                    state_next = from_op_reg ? ST_OUT : ST_IDLE;
                end
            end
            ST_OUT: begin
                if (out_take) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_valid  = (state_reg == ST_OUT);
    assign out_mode   = mode_reg;
    assign out_hit    = hit_reg;
    assign out_stored = st_reg;

endmodule
`default_nettype wire

@@ sv/bfil_div.sv @@
// ----------------------------------------------------------------------------
// bfil_div
// restoring remainder of a 64-bit value by the filter size, one bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none
module bfil_div import bfil_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [63:0]       dividend,
    input  wire logic [SIZE_W-1:0] divisor,
    output logic                   done,
    output logic [IDX_W-1:0]       rem
);

    logic [63:0]          q_reg, q_next;
    logic [SIZE_W:0]      r_reg, r_next;
    logic [SIZE_W-1:0]    d_reg, d_next;
    logic [DIV_CNT_W-1:0] n_reg, n_next;
    logic                 busy_reg, busy_next;
    logic [SIZE_W:0]      trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            n_reg    <= '0;
        end else begin
            busy_reg <= busy_next;
            n_reg    <= n_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign trial = {r_reg[SIZE_W-1:0], q_reg[63]};

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        n_next    = n_reg;
        busy_next = busy_reg;
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            n_next    = DIV_CNT_W'(64);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            q_next = {q_reg[62:0], 1'b0};
            r_next = (trial >= {1'b0, d_reg}) ? trial - {1'b0, d_reg} : trial;
            n_next = n_reg - 1'b1;
            if (n_reg == DIV_CNT_W'(1)) busy_next = 1'b0;
        end
    end

    assign done = !busy_reg && !start;
    assign rem  = r_reg[IDX_W-1:0];

endmodule
`default_nettype wire

@@ sv/bfil_dp.sv @@
// ----------------------------------------------------------------------------
// bfil_dp
// datapath: coefficient registers, hash accumulators, divider, bit store
// ----------------------------------------------------------------------------
`default_nettype none
module bfil_dp import bfil_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cmd_t              cmd,
    input  wire logic [63:0]       key_chunk,
    input  wire logic              cfg_we,
    input  wire logic [3:0]        cfg_idx,
    input  wire logic [63:0]       cfg_data,
    output logic [63:0]            cfg_rdata,
    output logic [2:0]             hash_count,
    output logic                   size_zero,
    output stat_t                  stat
);

    logic [2:0]        hc_reg;
    logic [SIZE_W-1:0] fb_reg;
    logic [1:0]        cb_reg;
    logic [63:0]       coef_reg [MAX_HASHES];
    logic [63:0]       acc_reg  [MAX_HASHES];
    logic [63:0]       masked;
    logic [SIZE_W-1:0] modulus;
    logic [IDX_W-1:0]  idx;
    logic              div_done;
    logic [WORD_W-1:0] mem [WORDS];
    logic [WORD_W-1:0] rd_reg;
    logic [IDX_W-1:0]  idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hc_reg <= 3'd1;
            fb_reg <= '0;
            cb_reg <= 2'd2;
            for (int i = 0; i < MAX_HASHES; i++) coef_reg[i] <= '0;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_HASH_COUNT:  hc_reg <= cfg_data[2:0];
                REG_FILTER_BITS: fb_reg <= cfg_data[SIZE_W-1:0];
                REG_CHUNK_BYTES: cb_reg <= cfg_data[1:0];
                default: begin
                    if (cfg_idx >= REG_COEF_0 && cfg_idx <= REG_COEF_LAST)
                        coef_reg[3'(cfg_idx - REG_COEF_0)] <= cfg_data;
                end
            endcase
        end
    end

    always_comb begin
        cfg_rdata = '0;
        unique case (cfg_idx)
            REG_HASH_COUNT:  cfg_rdata = 64'(hc_reg);
            REG_FILTER_BITS: cfg_rdata = 64'(fb_reg);
            REG_CHUNK_BYTES: cfg_rdata = 64'(cb_reg);
            default: begin
                if (cfg_idx >= REG_COEF_0 && cfg_idx <= REG_COEF_LAST)
                    cfg_rdata = coef_reg[3'(cfg_idx - REG_COEF_0)];
            end
        endcase
    end

    always_comb begin
        case (cb_reg)
            2'd0:    masked = {56'd0, key_chunk[7:0]};
            2'd1:    masked = {32'd0, key_chunk[31:0]};
            default: masked = key_chunk;
        endcase
    end

    // per hash lane: full 32x32 product of the low half, truncated 32x32 of the high half
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.acc_zero) begin
            for (int i = 0; i < MAX_HASHES; i++) acc_reg[i] <= '0;
        end else if (cmd.acc_load) begin
            for (int i = 0; i < MAX_HASHES; i++)
                acc_reg[i] <= acc_reg[i]
                              + ({32'd0, coef_reg[i][63:32]} * {32'd0, masked[31:0]})
                              + {(coef_reg[i][63:32] * masked[63:32]), 32'd0}
                              + {32'd0, coef_reg[i][31:0]};
        end
    end

    assign modulus    = (fb_reg > SIZE_W'(FILTER_DEPTH)) ? SIZE_W'(FILTER_DEPTH) : fb_reg;
    assign size_zero  = (modulus == '0);
    assign hash_count = hc_reg;

    bfil_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (acc_reg[cmd.hsel]),
        .divisor  (modulus),
        .done     (div_done),
        .rem      (idx)
    );

    always_ff @(posedge aclk) begin
        if (cmd.mem_read) idx_reg <= idx;
        if (cmd.mem_read) rd_reg <= mem[idx[IDX_W-1:BIT_W]];
        if (cmd.clr_write) mem[cmd.clr_addr] <= '0;
        else if (cmd.mem_write)
            mem[idx_reg[IDX_W-1:BIT_W]] <= rd_reg | (WORD_W'(1) << idx_reg[BIT_W-1:0]);
    end

    assign stat.div_done = div_done;
    assign stat.bit_set  = rd_reg[idx_reg[BIT_W-1:0]];

endmodule
`default_nettype wire

@@ sv/bloom_filter_insert_lookup.sv @@
// ----------------------------------------------------------------------------
// bloom_filter_insert_lookup
// bloom filter with multiply-add hashing over a 64k-bit store
// ----------------------------------------------------------------------------
// s_ beats carry one key chunk; s_tlast marks the last chunk of a key.
// a non-final chunk is taken and folded into five accumulators.
// on the last chunk each used hash is reduced by a bit-serial remainder unit
// and each hash's bit is then probed or set; a lookup still probes every hash.
// a clear op sweeps the store one 32-bit word a cycle, then gives a result. after
// reset the same sweep runs once with no result, and s_tready stays low while it
// runs; configuration writes are taken.
// one result beat is held in m_ until m_tready; no new chunk is taken
// while it waits. mode 3 beats are taken and dropped.
// ----------------------------------------------------------------------------
`default_nettype none
module bloom_filter_insert_lookup import bfil_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,  // mode[1:0], key_chunk[65:2], zero fill
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,  // done_mode[1:0], hit[2], stored[3], zero fill
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    cmd_t       cmd;
    stat_t      stat;
    logic       in_fire, cfg_we, size_zero, hit, stored;
    logic [2:0] hash_count;
    logic [1:0] out_mode;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign in_fire = s_tvalid && s_tready;

    bfil_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .key_chunk  (s_tdata[65:2]),
        .cfg_we     (cfg_we),
        .cfg_idx    (paddr[5:3] == 3'd0 && paddr[2:0] == 3'd0 ? 4'd0 : {1'b0, paddr[5:3]}),
        .cfg_data   (pwdata),
        .cfg_rdata  (prdata),
        .hash_count (hash_count),
        .size_zero  (size_zero),
        .stat       (stat)
    );

    bfil_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .in_mode    (s_tdata[1:0]),
        .in_last    (s_tlast),
        .hash_count (hash_count),
        .size_zero  (size_zero),
        .out_take   (m_tvalid && m_tready),
        .stat       (stat),
        .cmd        (cmd),
        .in_ready   (s_tready),
        .out_valid  (m_tvalid),
        .out_mode   (out_mode),
        .out_hit    (hit),
        .out_stored (stored)
    );

    assign m_tdata = {4'd0, stored, hit, out_mode};

    a_no_in_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("chunk taken while result pending");
    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped under stall");
    a_lookup_no_store: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == MODE_LOOKUP |-> !m_tdata[3])
        else $error("lookup reported stored");

endmodule
`default_nettype wire
